// ----- design/vlms_pkg.sv -----
// Shared types, field layout and helpers for the voxel LOD material select block.
`timescale 1ns / 1ps
package vlms_pkg;

   localparam int unsigned LaneCount = 8;
   localparam int unsigned AirPerLane = 3;
   localparam int unsigned ChildBits = 3;
   localparam int unsigned CountBits = 4;
   localparam int unsigned ParityBits = 3;
   localparam int unsigned MatW = 16;

   localparam logic [AirPerLane-1:0] AXIS_X = 3'b001;
   localparam logic [AirPerLane-1:0] AXIS_Y = 3'b010;
   localparam logic [AirPerLane-1:0] AXIS_Z = 3'b100;

   localparam int unsigned OccLsb = 0;
   localparam int unsigned AirLsb = OccLsb + LaneCount;
   localparam int unsigned ParityLsb = AirLsb + LaneCount * AirPerLane;
   localparam int unsigned MatLsb = ParityLsb + ParityBits;
   localparam int unsigned ReqFieldBits = MatLsb + LaneCount * MatW;
   localparam int unsigned ReqDataW = ((ReqFieldBits + 7) / 8) * 8;

   localparam int unsigned RspOccLsb = 0;
   localparam int unsigned RspMatLsb = RspOccLsb + 1;
   localparam int unsigned RspChildLsb = RspMatLsb + MatW;
   localparam int unsigned RspFieldBits = RspChildLsb + ChildBits;
   localparam int unsigned RspDataW = ((RspFieldBits + 7) / 8) * 8;

   typedef struct packed {
      logic occupied;
      logic exposed;
   } lane_flags_type;

   function automatic logic [ParityBits-1:0] wrap_parity(
      input logic [ParityBits-1:0] parity,
      input logic [CountBits-1:0] count
   );
      logic [ParityBits-1:0] r;
      r = parity;
      case (count)
         4'd1: r = '0;
         4'd2: r = {2'b00, parity[0]};
         4'd3: begin
            if (parity >= 3'd6) r = parity - 3'd6;
            else if (parity >= 3'd3) r = parity - 3'd3;
            else r = parity;
         end
         4'd4: r = {1'b0, parity[1:0]};
         4'd5: r = (parity >= 3'd5) ? parity - 3'd5 : parity;
         4'd6: r = (parity >= 3'd6) ? parity - 3'd6 : parity;
         4'd7: r = (parity == 3'd7) ? 3'd0 : parity;
         default: r = parity;
      endcase
      return r;
   endfunction

endpackage

// ----- design/voxel_lod_material_select_top.sv -----
// Top level of the voxel LOD material select block: lanes, merge and beat registers.
//
// Usage: each req beat carries one 2x2x2 voxel block (occupancy, outward air flags,
// coarse parity and eight child materials); each one yields exactly one rsp beat with
// the coarse occupancy, the picked material and the picked child index.
// Eight lanes, one per child, classify the children in parallel; a merge stage
// counts the candidates, wraps the parity by that count and picks the child.
// Path: an accepted req beat goes through the lane register, then the output register,
// to rsp_tvalid. Throughput: one beat per cycle while rsp_tready is not held low, set
// by the two-stage pipeline with one register per stage.
// Reset: synchronous, active high; clears both stage valid flags, so no rsp beat is
// pending afterwards. The block holds no other state between beats.
// Stall: while rsp_tready is low the output register holds its beat; the lane stage
// still accepts one more beat, after which req_tready drops until rsp moves.
`timescale 1ns / 1ps
module voxel_lod_material_select_top #(
   parameter int unsigned MATERIAL_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // block_occupancy[7:0], outward_air[31:8], lod_parity[34:32],
   // material_0..material_7 at [50:35] .. [162:147], zero pad [167:163]
   input  logic [vlms_pkg::ReqDataW-1:0]    req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // lod_occupied[0], lod_material[16:1], chosen_child[19:17], zero pad [23:20]
   output logic [vlms_pkg::RspDataW-1:0]    rsp_tdata
);
   import vlms_pkg::*;

   lane_flags_type [LaneCount-1:0] lane_flags;

   logic                                    s1_valid_ff, s1_valid_in;
   lane_flags_type [LaneCount-1:0]          s1_flags_ff;
   logic [ParityBits-1:0]                   s1_parity_ff;
   logic [LaneCount-1:0][MATERIAL_BITS-1:0] s1_mat_ff;

   logic                                    rsp_valid_ff, rsp_valid_in;
   logic                                    rsp_occ_ff;
   logic [MATERIAL_BITS-1:0]                rsp_mat_ff;
   logic [ChildBits-1:0]                    rsp_child_ff;

   logic                                    merge_occ;
   logic [MATERIAL_BITS-1:0]                merge_mat;
   logic [ChildBits-1:0]                    merge_child;
   logic                                    rsp_free;
   logic                                    s1_free;
   logic [MatW-1:0]                         mat_ext;

   for (genvar i = 0; i < LaneCount; i++) begin : g_lane
      vlms_lane u_lane (
         .occupied_i (req_tdata[OccLsb + i]),
         .air_i      (req_tdata[AirLsb + AirPerLane * i +: AirPerLane]),
         .flags_o    (lane_flags[i])
      );
   end

   vlms_merge #(
      .MATERIAL_BITS (MATERIAL_BITS)
   ) u_merge (
      .lane_flags_i (s1_flags_ff),
      .parity_i     (s1_parity_ff),
      .material_i   (s1_mat_ff),
      .occupied_o   (merge_occ),
      .material_o   (merge_mat),
      .chosen_o     (merge_child)
   );

   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign s1_free = !s1_valid_ff || rsp_free;
   assign req_tready = s1_free;

   always_comb begin
      s1_valid_in = s1_free ? req_tvalid : s1_valid_ff;
      rsp_valid_in = rsp_free ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free && req_tvalid) begin
         s1_flags_ff <= lane_flags;
         s1_parity_ff <= req_tdata[ParityLsb +: ParityBits];
         for (int i = 0; i < LaneCount; i++) begin
            s1_mat_ff[i] <= req_tdata[MatLsb + MatW * i +: MATERIAL_BITS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free && s1_valid_ff) begin
         rsp_occ_ff <= merge_occ;
         rsp_mat_ff <= merge_mat;
         rsp_child_ff <= merge_child;
      end
   end

   assign mat_ext = MatW'(rsp_mat_ff);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = RspDataW'({rsp_child_ff, mat_ext, rsp_occ_ff});

endmodule

// ----- design/vlms_lane.sv -----
// Per-child lane: occupancy and air exposure of one child voxel.
`timescale 1ns / 1ps
module vlms_lane (
   input  logic                                   occupied_i,
   input  logic [vlms_pkg::AirPerLane-1:0]        air_i,
   output vlms_pkg::lane_flags_type               flags_o
);
   import vlms_pkg::*;

   always_comb begin
      flags_o.occupied = occupied_i;
      flags_o.exposed = occupied_i & (|(air_i & (AXIS_X | AXIS_Y | AXIS_Z)));
   end

endmodule

// ----- design/vlms_merge.sv -----
// Merge stage: candidate set, wrapped rank and material pick across lanes.
`timescale 1ns / 1ps
module vlms_merge #(
   parameter int unsigned MATERIAL_BITS = 16
) (
   input  vlms_pkg::lane_flags_type [vlms_pkg::LaneCount-1:0] lane_flags_i,
   input  logic [vlms_pkg::ParityBits-1:0]                     parity_i,
   input  logic [vlms_pkg::LaneCount-1:0][MATERIAL_BITS-1:0]   material_i,
   output logic                                                occupied_o,
   output logic [MATERIAL_BITS-1:0]                            material_o,
   output logic [vlms_pkg::ChildBits-1:0]                      chosen_o
);
   import vlms_pkg::*;

   logic [LaneCount-1:0] occ_mask;
   logic [LaneCount-1:0] exp_mask;
   logic [LaneCount-1:0] cand_mask;
   logic [LaneCount-1:0] hit;
   logic [CountBits-1:0] count;
   logic [CountBits-1:0] rank [LaneCount];
   logic [ParityBits-1:0] target;

   always_comb begin
      for (int i = 0; i < LaneCount; i++) begin
         occ_mask[i] = lane_flags_i[i].occupied;
         exp_mask[i] = lane_flags_i[i].exposed;
      end
      cand_mask = (|exp_mask) ? exp_mask : occ_mask;
      count = '0;
      for (int i = 0; i < LaneCount; i++) begin
         rank[i] = count;
         count = count + CountBits'(cand_mask[i]);
      end
      target = wrap_parity(parity_i, count);
      for (int i = 0; i < LaneCount; i++) begin
         hit[i] = cand_mask[i] && (rank[i] == CountBits'(target));
      end
      occupied_o = |occ_mask;
      chosen_o = '0;
      material_o = '0;
      for (int i = 0; i < LaneCount; i++) begin
         if (hit[i]) begin
            chosen_o = chosen_o | ChildBits'(i);
            material_o = material_o | material_i[i];
         end
      end
   end

endmodule

// ----- tb/voxel_lod_material_select_top_tb.sv -----
// Testbench for the voxel LOD material select block: random blocks, stalls and a scoreboard.
`timescale 1ns / 1ps
module voxel_lod_material_select_top_tb;
   import vlms_pkg::*;

   localparam int unsigned MATERIAL_BITS = 16;
   localparam int unsigned IDLE_LIMIT = 1000;
   localparam int unsigned RANDOM_BLOCKS = 1200;
   localparam int unsigned CALM_TAIL = 200;

   typedef struct packed {
      logic [LaneCount-1:0][MatW-1:0] material;
      logic [ParityBits-1:0]          parity;
      logic [LaneCount*AirPerLane-1:0] outward_air;
      logic [LaneCount-1:0]           occupancy;
   } voxel_block_type;

   typedef struct packed {
      logic                 occupied;
      logic [MatW-1:0]      material;
      logic [ChildBits-1:0] child;
   } lod_pick_type;

   class material_scoreboard;
      lod_pick_type expected_q[$];
      int unsigned  mismatches;

      function new();
         mismatches = 0;
      endfunction

      function lod_pick_type select_material(voxel_block_type blk);
         logic [LaneCount-1:0] cand;
         logic [MatW-1:0]      mat_mask;
         int unsigned          count;
         int unsigned          target;
         int unsigned          seen;
         int unsigned          pick;
         bit                   found;
         lod_pick_type         r;
         r = '0;
         mat_mask = MatW'((32'h1 << MATERIAL_BITS) - 1);
         if (blk.occupancy == '0) return r;
         cand = '0;
         for (int c = 0; c < LaneCount; c++) begin
            if (blk.occupancy[c] &&
                (blk.outward_air[AirPerLane*c +: AirPerLane] & (AXIS_X | AXIS_Y | AXIS_Z)) != 0)
               cand[c] = 1'b1;
         end
         if (cand == '0) cand = blk.occupancy;
         count = $countones(cand);
         target = blk.parity % count;
         seen = 0;
         pick = 0;
         found = 0;
         for (int c = 0; c < LaneCount; c++) begin
            if (cand[c] && !found) begin
               if (seen == target) begin
                  pick = c;
                  found = 1;
               end
               seen++;
            end
         end
         r.occupied = 1'b1;
         r.material = blk.material[pick] & mat_mask;
         r.child = ChildBits'(pick);
         return r;
      endfunction

      function void note_block(voxel_block_type blk);
         expected_q.push_back(select_material(blk));
      endfunction

      function void check_beat(logic [RspDataW-1:0] data);
         lod_pick_type exp_pick;
         lod_pick_type got;
         got.occupied = data[RspOccLsb];
         got.material = data[RspMatLsb +: MatW];
         got.child = data[RspChildLsb +: ChildBits];
         if (expected_q.size() == 0) begin
            $error("unexpected rsp beat: %0h", data);
            mismatches++;
            return;
         end
         exp_pick = expected_q.pop_front();
         if (got.occupied !== exp_pick.occupied) begin
            $error("lod_occupied: expected %0h, got %0h", exp_pick.occupied, got.occupied);
            mismatches++;
         end
         if (got.material !== exp_pick.material) begin
            $error("lod_material: expected %0h, got %0h", exp_pick.material, got.material);
            mismatches++;
         end
         if (got.child !== exp_pick.child) begin
            $error("chosen_child: expected %0h, got %0h", exp_pick.child, got.child);
            mismatches++;
         end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspDataW-1:0] rsp_tdata;

   material_scoreboard board;
   int unsigned        gap_pct;
   int unsigned        stall_pct;
   int unsigned        stall_left;
   int unsigned        quiet_cycles;

   voxel_lod_material_select_top #(
      .MATERIAL_BITS(MATERIAL_BITS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic voxel_block_type make_block(
      logic [LaneCount-1:0] occ,
      logic [LaneCount*AirPerLane-1:0] air,
      logic [ParityBits-1:0] parity
   );
      voxel_block_type blk;
      blk.occupancy = occ;
      blk.outward_air = air;
      blk.parity = parity;
      for (int i = 0; i < LaneCount; i++) blk.material[i] = MatW'($urandom);
      return blk;
   endfunction

   task automatic send_block(voxel_block_type blk);
      logic [ReqDataW-1:0] beat;
      int unsigned         gap;
      beat = '0;
      beat[OccLsb +: LaneCount] = blk.occupancy;
      beat[AirLsb +: LaneCount*AirPerLane] = blk.outward_air;
      beat[ParityLsb +: ParityBits] = blk.parity;
      for (int i = 0; i < LaneCount; i++) beat[MatLsb + i*MatW +: MatW] = blk.material[i];
      gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 9) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = beat;
      do @(posedge clock); while (!req_tready);
      board.note_block(blk);
   endtask

   // drive rsp_tready with random stall bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready = 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         rsp_tready = 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_tready = 1'b0;
         stall_left = $urandom_range(1, 9) - 1;
      end else begin
         rsp_tready = 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_beat(rsp_tdata);
   end

   initial begin : watchdog
      quiet_cycles = 0;
      while (quiet_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      voxel_block_type                 blk;
      logic [LaneCount-1:0]            occ;
      logic [LaneCount*AirPerLane-1:0] air;
      board = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      gap_pct = 20;
      stall_pct = 20;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty blocks, field extremes
      blk = make_block(8'h00, 24'hFFFFFF, 3'd7);
      blk.material = '1;
      send_block(blk);
      blk = make_block(8'h00, 24'h000000, 3'd0);
      blk.material = '0;
      send_block(blk);
      // all occupied, nothing exposed: every parity
      for (int p = 0; p < 8; p++) send_block(make_block(8'hFF, 24'h000000, ParityBits'(p)));
      blk = make_block(8'hFF, 24'hFFFFFF, 3'd5);
      blk.material = '1;
      send_block(blk);
      // air on empty children only
      send_block(make_block(8'h03, 24'hFFFFC0, 3'd3));
      // one axis at a time
      send_block(make_block(8'hFF, 24'(AXIS_X) << (AirPerLane*3), 3'd6));
      send_block(make_block(8'hFF, 24'(AXIS_Y) << (AirPerLane*5), 3'd1));
      send_block(make_block(8'hFF, 24'(AXIS_Z) << (AirPerLane*7), 3'd2));
      // parity wrap for candidate counts 1, 2, 3, 5, 6 and 7
      send_block(make_block(8'h07, 24'h000000, 3'd7));
      send_block(make_block(8'h1F, 24'h000000, 3'd6));
      send_block(make_block(8'h3F, 24'h000000, 3'd7));
      send_block(make_block(8'h7F, 24'h000000, 3'd7));
      send_block(make_block(8'h80, 24'h000000, 3'd7));
      send_block(make_block(8'hA5, (24'(AXIS_Y) << (AirPerLane*7)) | 24'(AXIS_Z), 3'd3));

      for (int n = 0; n < RANDOM_BLOCKS; n++) begin
         if (n % 100 == 0) begin
            gap_pct = 20 * $urandom_range(0, 3);
            stall_pct = 20 * $urandom_range(0, 3);
         end
         if (n >= RANDOM_BLOCKS - CALM_TAIL) begin
            gap_pct = 0;
            stall_pct = 0;
         end
         case ($urandom_range(0, 5))
            0: occ = 8'h00;
            1: occ = 8'hFF;
            2: occ = 8'h01 << $urandom_range(0, 7);
            3: occ = 8'($urandom & $urandom);
            default: occ = 8'($urandom);
         endcase
         case ($urandom_range(0, 3))
            0: air = '0;
            1: air = 24'($urandom);
            2: air = 24'($urandom & $urandom & $urandom);
            default: air = 24'h000001 << $urandom_range(0, 23);
         endcase
         send_block(make_block(occ, air, ParityBits'($urandom_range(0, 7))));
      end
      @(negedge clock);
      req_tvalid = 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (board.pending() != 0) begin
         $error("rsp beats missing: %0d", board.pending());
         board.mismatches++;
      end
      if (board.mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
